>>> rtl/c_source_tokenizer_unit_macros.svh
// Assertion shorthands for the tokenizer checker.
`ifndef C_SOURCE_TOKENIZER_UNIT_MACROS_SVH
`define C_SOURCE_TOKENIZER_UNIT_MACROS_SVH

// antecedent holds -> consequent holds in the same cycle
`define CSTU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent holds -> consequent holds in the next cycle
`define CSTU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/cstu_pkg.sv
`default_nettype none
package cstu_pkg;

  localparam int unsigned OFF_W   = 24;
  localparam int unsigned KW_MAX  = 9;
  localparam int unsigned KW_BITS = KW_MAX * 8;
  localparam int unsigned WLEN_W  = $clog2(KW_MAX + 2);
  localparam int unsigned MAX_TOK = 4;

  typedef logic [OFF_W-1:0]  off_t;
  typedef logic [7:0]        byte_t;
  typedef logic [5:0]        cls_t;
  typedef logic [WLEN_W-1:0] wlen_t;

  localparam off_t OFF_MAX = '1;
  localparam off_t LEN1 = OFF_W'(1);
  localparam off_t LEN2 = OFF_W'(2);
  localparam off_t LEN3 = OFF_W'(3);
  localparam logic [2:0] TOK_CAP = 3'(MAX_TOK);

  localparam int unsigned TOK_BITS = 2 * OFF_W + 6;
  localparam int unsigned TDATA_W  = ((TOK_BITS + 7) / 8) * 8;
  localparam int unsigned TPAD_W   = TDATA_W - TOK_BITS;

  localparam cls_t CLS_IDENT     = 6'd0;
  localparam cls_t CLS_TYPE      = 6'd1;
  localparam cls_t CLS_QUAL      = 6'd2;
  localparam cls_t CLS_CTRL      = 6'd3;
  localparam cls_t CLS_NUM       = 6'd4;
  localparam cls_t CLS_STR       = 6'd5;
  localparam cls_t CLS_CHR       = 6'd6;
  localparam cls_t CLS_SPACE     = 6'd7;
  localparam cls_t CLS_COMMENT   = 6'd8;
  localparam cls_t CLS_DIR       = 6'd9;
  localparam cls_t CLS_BLOCK_BEG = 6'd10;
  localparam cls_t CLS_BLOCK_END = 6'd11;
  localparam cls_t CLS_TUPLE_BEG = 6'd12;
  localparam cls_t CLS_TUPLE_END = 6'd13;
  localparam cls_t CLS_INDEX_BEG = 6'd14;
  localparam cls_t CLS_INDEX_END = 6'd15;
  localparam cls_t CLS_OP1       = 6'd18;
  localparam cls_t CLS_OP2       = 6'd19;
  localparam cls_t CLS_OP3       = 6'd20;
  localparam cls_t CLS_OP4       = 6'd21;
  localparam cls_t CLS_OP5       = 6'd22;
  localparam cls_t CLS_OP6       = 6'd23;
  localparam cls_t CLS_OP7       = 6'd24;
  localparam cls_t CLS_OP8       = 6'd25;
  localparam cls_t CLS_OP9       = 6'd26;
  localparam cls_t CLS_OP10      = 6'd27;
  localparam cls_t CLS_OP11      = 6'd28;
  localparam cls_t CLS_OP12      = 6'd29;
  localparam cls_t CLS_OP13      = 6'd30;
  localparam cls_t CLS_OP14      = 6'd31;
  localparam cls_t CLS_COMMA     = 6'd32;
  localparam cls_t CLS_SEMI      = 6'd33;
  localparam cls_t CLS_ELLIPSIS  = 6'd34;
  localparam cls_t CLS_OTHER     = 6'd35;

  typedef enum logic [3:0] {
    MODE_IDLE, MODE_IDENT, MODE_NUM, MODE_NUM_SUF, MODE_NUM_ESIGN, MODE_NUM_EDIG,
    MODE_STR, MODE_CHR, MODE_SYSINC, MODE_LCOM, MODE_BCOM, MODE_BCOM_STAR,
    MODE_SPACE, MODE_SPACE_BSL, MODE_DIR, MODE_PEND
  } mode_t;

  typedef struct packed {
    mode_t                   mode;
    off_t                    start;
    off_t                    len;
    byte_t                   la0;
    byte_t                   la1;
    logic [1:0]              lac;
    logic [KW_MAX-1:0][7:0]  word;
    wlen_t                   wlen;
    logic                    pv;
    logic                    inc;
    logic                    esc;
  } scan_st_t;

  typedef struct packed {
    cls_t cls;
    off_t len;
    off_t start;
  } tok_t;

  typedef struct packed {
    scan_st_t                 s;
    logic [2:0]               n;
    tok_t [MAX_TOK-1:0]       tok;
  } ctx_t;

  typedef struct packed {
    logic [KW_BITS-1:0] text;
    wlen_t              len;
    cls_t               cls;
  } kw_t;

  localparam int unsigned KW_N = 37;
  localparam kw_t KW_LIST [KW_N] = '{
    '{KW_BITS'("do"), 4'd2, CLS_CTRL},       '{KW_BITS'("if"), 4'd2, CLS_CTRL},
    '{KW_BITS'("for"), 4'd3, CLS_CTRL},      '{KW_BITS'("int"), 4'd3, CLS_TYPE},
    '{KW_BITS'("case"), 4'd4, CLS_CTRL},     '{KW_BITS'("else"), 4'd4, CLS_CTRL},
    '{KW_BITS'("goto"), 4'd4, CLS_CTRL},     '{KW_BITS'("char"), 4'd4, CLS_TYPE},
    '{KW_BITS'("enum"), 4'd4, CLS_TYPE},     '{KW_BITS'("long"), 4'd4, CLS_TYPE},
    '{KW_BITS'("void"), 4'd4, CLS_TYPE},     '{KW_BITS'("bool"), 4'd4, CLS_TYPE},
    '{KW_BITS'("auto"), 4'd4, CLS_QUAL},     '{KW_BITS'("break"), 4'd5, CLS_CTRL},
    '{KW_BITS'("while"), 4'd5, CLS_CTRL},    '{KW_BITS'("float"), 4'd5, CLS_TYPE},
    '{KW_BITS'("short"), 4'd5, CLS_TYPE},    '{KW_BITS'("union"), 4'd5, CLS_TYPE},
    '{KW_BITS'("const"), 4'd5, CLS_QUAL},    '{KW_BITS'("return"), 4'd6, CLS_CTRL},
    '{KW_BITS'("switch"), 4'd6, CLS_CTRL},   '{KW_BITS'("double"), 4'd6, CLS_TYPE},
    '{KW_BITS'("struct"), 4'd6, CLS_TYPE},   '{KW_BITS'("extern"), 4'd6, CLS_QUAL},
    '{KW_BITS'("inline"), 4'd6, CLS_QUAL},   '{KW_BITS'("signed"), 4'd6, CLS_QUAL},
    '{KW_BITS'("static"), 4'd6, CLS_QUAL},   '{KW_BITS'("sizeof"), 4'd6, CLS_OP2},
    '{KW_BITS'("default"), 4'd7, CLS_CTRL},  '{KW_BITS'("complex"), 4'd7, CLS_TYPE},
    '{KW_BITS'("continue"), 4'd8, CLS_CTRL}, '{KW_BITS'("register"), 4'd8, CLS_QUAL},
    '{KW_BITS'("restrict"), 4'd8, CLS_QUAL}, '{KW_BITS'("unsigned"), 4'd8, CLS_QUAL},
    '{KW_BITS'("volatile"), 4'd8, CLS_QUAL}, '{KW_BITS'("_Alignof"), 4'd8, CLS_OP2},
    '{KW_BITS'("imaginary"), 4'd9, CLS_TYPE}
  };

  localparam logic [63:0] INC_TEXT = "#include";

  function automatic off_t sat_inc(off_t a);
    return (a == OFF_MAX) ? a : a + 1'b1;
  endfunction

  function automatic off_t sat_add(off_t a, off_t b);
    logic [OFF_W:0] r;
    r = {1'b0, a} + {1'b0, b};
    return r[OFF_W] ? OFF_MAX : r[OFF_W-1:0];
  endfunction

  function automatic logic is_digit(byte_t c);
    return c inside {["0":"9"]};
  endfunction

  function automatic logic is_start(byte_t c);
    return c inside {["a":"z"], ["A":"Z"], "_"};
  endfunction

  function automatic logic is_word(byte_t c);
    return is_start(c) || is_digit(c);
  endfunction

  function automatic logic is_suffix(byte_t c);
    return c inside {"u", "U", "l", "L"};
  endfunction

  function automatic ctx_t f_emit(ctx_t x, off_t len, cls_t cls);
    if (x.n < TOK_CAP) begin
      x.tok[x.n[1:0]].start = x.s.start;
      x.tok[x.n[1:0]].len   = len;
      x.tok[x.n[1:0]].cls   = cls;
      x.n = x.n + 3'd1;
    end
    if (cls != CLS_SPACE && cls != CLS_COMMENT) begin
      x.s.pv = cls inside {CLS_IDENT, CLS_NUM, CLS_STR, CLS_CHR,
                           CLS_TUPLE_END, CLS_INDEX_END};
    end
    return x;
  endfunction

  function automatic ctx_t f_store(ctx_t x, byte_t c);
    if (x.s.wlen < WLEN_W'(KW_MAX)) x.s.word[x.s.wlen] = c;
    if (x.s.wlen <= WLEN_W'(KW_MAX)) x.s.wlen = x.s.wlen + 1'b1;
    return x;
  endfunction

  function automatic cls_t f_classify(logic [KW_MAX-1:0][7:0] word, wlen_t wlen);
    logic [KW_BITS-1:0] pw;
    cls_t               cls;
    pw  = '0;
    cls = CLS_IDENT;
    for (int i = 0; i < KW_MAX; i++) begin
      if (WLEN_W'(i) < wlen) pw = {pw[KW_BITS-9:0], word[i]};
    end
    if (wlen <= WLEN_W'(KW_MAX)) begin
      for (int k = 0; k < KW_N; k++) begin
        if (KW_LIST[k].len == wlen && KW_LIST[k].text == pw) cls = KW_LIST[k].cls;
      end
    end
    return cls;
  endfunction

  // directive text so far is a prefix of #include
  function automatic logic f_inc_match(logic [KW_MAX-1:0][7:0] word, wlen_t wlen);
    logic ok;
    ok = (wlen <= WLEN_W'(8));
    for (int i = 0; i < 8; i++) begin
      if (WLEN_W'(i) < wlen && word[i] != INC_TEXT[8*(7-i) +: 8]) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic ctx_t f_begin(ctx_t x, byte_t c, off_t pos);
    cls_t cls;
    cls = CLS_OTHER;
    x.s.start = pos;
    x.s.len   = LEN1;
    x.s.esc   = 1'b0;
    x.s.lac   = 2'd0;
    x.s.mode  = MODE_IDLE;
    if (is_start(c)) begin
      x.s.wlen = '0;
      x = f_store(x, c);
      x.s.mode = MODE_IDENT;
    end else if (is_digit(c)) begin
      x.s.mode = MODE_NUM;
    end else if (c == 8'h22) begin
      x.s.mode = MODE_STR;
    end else if (c == 8'h27) begin
      x.s.mode = MODE_CHR;
    end else if (c == 8'h0A) begin
      x.s.inc  = 1'b0;
      x.s.mode = MODE_SPACE;
    end else if (c inside {8'h20, 8'h09, 8'h0D}) begin
      x.s.mode = MODE_SPACE;
    end else if (c == "<" && x.s.inc) begin
      x.s.mode = MODE_SYSINC;
    end else if (c inside {"<", "/", 8'h5C, "#", ".", "+", "-", "*", "%", "=", "!",
                           ">", "&", "|", "^"}) begin
      x.s.la0  = c;
      x.s.lac  = 2'd1;
      x.s.mode = MODE_PEND;
    end else begin
      case (c)
        "{":      cls = CLS_BLOCK_BEG;
        "}":      cls = CLS_BLOCK_END;
        "(":      cls = CLS_TUPLE_BEG;
        ")":      cls = CLS_TUPLE_END;
        "[":      cls = CLS_INDEX_BEG;
        "]":      cls = CLS_INDEX_END;
        ",":      cls = CLS_COMMA;
        ";":      cls = CLS_SEMI;
        "~":      cls = CLS_OP2;
        "?", ":": cls = CLS_OP13;
        default:  cls = CLS_OTHER;
      endcase
      x = f_emit(x, LEN1, cls);
    end
    return x;
  endfunction

  function automatic ctx_t f_switch(ctx_t x, mode_t m);
    x.s.lac  = 2'd0;
    x.s.mode = m;
    x.s.len  = LEN2;
    return x;
  endfunction

  // one held operator byte against the next byte (zero at end of source)
  function automatic ctx_t f_pend1(ctx_t x, byte_t c, off_t pos, logic at_end);
    byte_t b;
    cls_t  cls;
    logic  take2;
    logic  done;
    logic  pv;
    b     = at_end ? 8'h00 : c;
    cls   = CLS_OTHER;
    take2 = 1'b0;
    done  = 1'b0;
    pv    = x.s.pv;
    case (x.s.la0)
      "/": begin
        if (b == "/") begin
          x = f_switch(x, MODE_LCOM); done = 1'b1;
        end else if (b == "*") begin
          x = f_switch(x, MODE_BCOM_STAR); done = 1'b1;
        end else if (b == "=") begin
          cls = CLS_OP14; take2 = 1'b1;
        end else cls = CLS_OP3;
      end
      8'h5C: begin
        if (b == 8'h0A) begin
          x.s.inc = 1'b0;
          x = f_switch(x, MODE_SPACE); done = 1'b1;
        end else cls = CLS_OTHER;
      end
      "#": begin
        if (at_end) cls = CLS_DIR;
        else if (is_start(b)) begin
          x.s.wlen = '0;
          x = f_store(x, "#");
          x = f_store(x, b);
          x = f_switch(x, MODE_DIR); done = 1'b1;
        end else if (b == "#") begin
          cls = CLS_DIR; take2 = 1'b1;
        end else cls = CLS_OTHER;
      end
      ".", ">", "<": begin
        if (b == x.s.la0) begin
          x.s.la1 = c; x.s.lac = 2'd2; x.s.len = LEN2; done = 1'b1;
        end else if (x.s.la0 == ".") cls = CLS_OP1;
        else if (b == "=") begin
          cls = CLS_OP6; take2 = 1'b1;
        end else cls = CLS_OP6;
      end
      "+": begin
        if (b == "+") begin cls = CLS_OP2; take2 = 1'b1; end
        else if (b == "=") begin cls = CLS_OP14; take2 = 1'b1; end
        else cls = pv ? CLS_OP4 : CLS_OP2;
      end
      "-": begin
        if (b == "-" || b == ">") begin cls = CLS_OP2; take2 = 1'b1; end
        else if (b == "=") begin cls = CLS_OP14; take2 = 1'b1; end
        else cls = pv ? CLS_OP4 : CLS_OP2;
      end
      "*": begin
        if (b == "=") begin cls = CLS_OP14; take2 = 1'b1; end
        else cls = pv ? CLS_OP3 : CLS_OP2;
      end
      "%": begin
        if (b == "=") begin cls = CLS_OP14; take2 = 1'b1; end
        else cls = CLS_OP3;
      end
      "=": begin
        if (b == "=") begin cls = CLS_OP7; take2 = 1'b1; end
        else cls = CLS_OP14;
      end
      "!": begin
        if (b == "=") begin cls = CLS_OP7; take2 = 1'b1; end
        else cls = CLS_OP2;
      end
      "&": begin
        if (b == "&") begin cls = CLS_OP11; take2 = 1'b1; end
        else if (b == "=") begin cls = CLS_OP14; take2 = 1'b1; end
        else cls = pv ? CLS_OP8 : CLS_OP2;
      end
      "|": begin
        if (b == "|") begin cls = CLS_OP12; take2 = 1'b1; end
        else if (b == "=") begin cls = CLS_OP14; take2 = 1'b1; end
        else cls = CLS_OP10;
      end
      "^": begin
        if (b == "=") begin cls = CLS_OP14; take2 = 1'b1; end
        else cls = CLS_OP9;
      end
      default: cls = CLS_OTHER;
    endcase
    if (!done) begin
      x.s.lac  = 2'd0;
      x.s.mode = MODE_IDLE;
      x = f_emit(x, take2 ? LEN2 : LEN1, cls);
      if (!take2 && !at_end) x = f_begin(x, c, pos);
    end
    return x;
  endfunction

  // held operator, one or two bytes deep
  function automatic ctx_t f_pend(ctx_t x, byte_t c, off_t pos, logic at_end);
    byte_t b;
    off_t  p1;
    b  = at_end ? 8'h00 : c;
    p1 = sat_inc(x.s.start);
    if (x.s.lac == 2'd2) begin
      x.s.lac  = 2'd0;
      x.s.mode = MODE_IDLE;
      if (x.s.la0 == ".") begin
        if (b == ".") x = f_emit(x, LEN3, CLS_ELLIPSIS);
        else begin
          x = f_emit(x, LEN1, CLS_OP1);
          x = f_begin(x, x.s.la1, p1);
          if (!at_end) x = f_pend1(x, c, pos, 1'b0);
        end
      end else begin
        if (b == "=") x = f_emit(x, LEN3, CLS_OP14);
        else begin
          x = f_emit(x, LEN2, CLS_OP5);
          if (!at_end) x = f_begin(x, c, pos);
        end
      end
    end else begin
      x = f_pend1(x, c, pos, at_end);
    end
    return x;
  endfunction

  function automatic ctx_t f_finish(ctx_t x);
    mode_t m;
    off_t  l;
    logic  incm;
    m = x.s.mode;
    l = (x.s.len > LEN1) ? x.s.len - 1'b1 : LEN1;
    incm = f_inc_match(x.s.word, x.s.wlen);
    x.s.mode = MODE_IDLE;
    case (m)
      MODE_IDENT: x = f_emit(x, x.s.len, f_classify(x.s.word, x.s.wlen));
      MODE_NUM, MODE_NUM_SUF, MODE_NUM_ESIGN, MODE_NUM_EDIG:
        x = f_emit(x, x.s.len, CLS_NUM);
      MODE_STR, MODE_SYSINC: x = f_emit(x, x.s.len, CLS_STR);
      MODE_CHR: x = f_emit(x, x.s.len, CLS_CHR);
      MODE_LCOM, MODE_BCOM, MODE_BCOM_STAR: x = f_emit(x, x.s.len, CLS_COMMENT);
      MODE_SPACE: x = f_emit(x, x.s.len, CLS_SPACE);
      MODE_SPACE_BSL: begin
        // backslash not followed by newline: split it off the run
        x = f_emit(x, l, CLS_SPACE);
        x = f_begin(x, 8'h5C, sat_add(x.s.start, l));
      end
      MODE_DIR: begin
        x = f_emit(x, x.s.len, CLS_DIR);
        if (incm) x.s.inc = 1'b1;
      end
      MODE_PEND: begin
        x.s.mode = MODE_PEND;
        x = f_pend(x, 8'h00, '0, 1'b1);
      end
      default: x.s.mode = MODE_IDLE;
    endcase
    return x;
  endfunction

  // token ends before c: close it and start over with c
  function automatic ctx_t f_fall(ctx_t x, byte_t c, off_t pos);
    x = f_finish(x);
    if (x.s.mode == MODE_PEND) x = f_pend1(x, c, pos, 1'b0);
    else x = f_begin(x, c, pos);
    return x;
  endfunction

  function automatic ctx_t f_num(ctx_t x, byte_t c, off_t pos);
    x.s.mode = MODE_NUM;
    if (is_digit(c) || c == ".") x.s.len = sat_inc(x.s.len);
    else if (is_suffix(c)) begin
      x.s.len = sat_inc(x.s.len); x.s.mode = MODE_NUM_SUF;
    end else if (c == "e" || c == "E") begin
      x.s.len = sat_inc(x.s.len); x.s.mode = MODE_NUM_ESIGN;
    end else x = f_fall(x, c, pos);
    return x;
  endfunction

  function automatic ctx_t f_process(ctx_t x, byte_t c, off_t pos);
    byte_t q;
    q = (x.s.mode == MODE_STR) ? 8'h22 : 8'h27;
    case (x.s.mode)
      MODE_IDLE: x = f_begin(x, c, pos);
      MODE_PEND: x = f_pend(x, c, pos, 1'b0);
      MODE_IDENT, MODE_DIR: begin
        if (is_word(c)) begin
          x = f_store(x, c); x.s.len = sat_inc(x.s.len);
        end else x = f_fall(x, c, pos);
      end
      MODE_NUM: x = f_num(x, c, pos);
      MODE_NUM_SUF: begin
        if (is_suffix(c)) begin
          x.s.mode = MODE_NUM; x.s.len = sat_inc(x.s.len);
        end else x = f_num(x, c, pos);
      end
      MODE_NUM_ESIGN, MODE_NUM_EDIG: begin
        if (is_digit(c) || (x.s.mode == MODE_NUM_ESIGN && c inside {"+", "-"})) begin
          x.s.mode = MODE_NUM_EDIG; x.s.len = sat_inc(x.s.len);
        end else x = f_num(x, c, pos);
      end
      MODE_STR, MODE_CHR: begin
        x.s.len = sat_inc(x.s.len);
        if (x.s.esc) x.s.esc = 1'b0;
        else if (c == 8'h5C) x.s.esc = 1'b1;
        else if (c == q) x = f_finish(x);
      end
      MODE_SYSINC: begin
        x.s.len = sat_inc(x.s.len);
        if (c == ">") x = f_finish(x);
      end
      MODE_LCOM: begin
        if (c != 8'h0A) x.s.len = sat_inc(x.s.len);
        else x = f_fall(x, c, pos);
      end
      MODE_BCOM: begin
        x.s.len = sat_inc(x.s.len);
        if (c == "*") x.s.mode = MODE_BCOM_STAR;
      end
      MODE_BCOM_STAR: begin
        x.s.len = sat_inc(x.s.len);
        if (c == "/") x = f_finish(x);
        else x.s.mode = MODE_BCOM;
      end
      MODE_SPACE: begin
        if (c inside {8'h20, 8'h09, 8'h0D, 8'h0A}) begin
          if (c == 8'h0A) x.s.inc = 1'b0;
          x.s.len = sat_inc(x.s.len);
        end else if (c == 8'h5C) begin
          x.s.len = sat_inc(x.s.len); x.s.mode = MODE_SPACE_BSL;
        end else x = f_fall(x, c, pos);
      end
      MODE_SPACE_BSL: begin
        if (c == 8'h0A) begin
          x.s.inc = 1'b0; x.s.len = sat_inc(x.s.len); x.s.mode = MODE_SPACE;
        end else x = f_fall(x, c, pos);
      end
      default: x = f_begin(x, c, pos);
    endcase
    return x;
  endfunction

  function automatic ctx_t f_step(scan_st_t s, byte_t c, logic at_end, off_t pos);
    ctx_t x;
    x.s   = s;
    x.n   = 3'd0;
    x.tok = '0;
    x = f_process(x, c, pos);
    if (at_end) begin
      // at most two closes reach idle: a split backslash or a held '..'
      if (x.s.mode != MODE_IDLE) x = f_finish(x);
      if (x.s.mode != MODE_IDLE) x = f_finish(x);
      x.s.mode  = MODE_IDLE;
      x.s.start = '0;
      x.s.len   = '0;
      x.s.lac   = 2'd0;
      x.s.wlen  = '0;
      x.s.pv    = 1'b0;
      x.s.inc   = 1'b0;
      x.s.esc   = 1'b0;
    end
    return x;
  endfunction

endpackage
`default_nettype wire

>>> rtl/c_source_tokenizer_unit.sv
// A byte passes the input register, then the result bank, to the result side.
// Throughput: one source byte per cycle while each byte yields at most one token
// and out_tready is high; the four-entry result bank sets the pace: a byte that
// yields k tokens (k up to 4) holds it until all k leave, one per ready cycle.
// Reset: rst_n low at a clock edge clears position, scan control state and both channels.
`default_nettype none
module c_source_tokenizer_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] source_byte
  input  wire logic        in_tlast,   // end_of_source
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [cstu_pkg::TDATA_W-1:0] out_tdata,
  // [23:0] token_start, [47:24] token_length, [53:48] token_class, rest zero
  output logic             out_tlast   // last_token
);

  // input register: one byte waiting to be scanned
  logic                  in_v_r;
  cstu_pkg::byte_t       in_byte_r;
  logic                  in_end_r;

  // scanner state and running byte offset
  cstu_pkg::scan_st_t    st_r, st_nxt;
  cstu_pkg::off_t        pos_r, pos_nxt;

  // result bank: tokens of one byte, drained from head_r
  cstu_pkg::tok_t [cstu_pkg::MAX_TOK-1:0] bank_r;
  logic [2:0]            rem_r;
  logic [1:0]            head_r;

  cstu_pkg::ctx_t        step_ctx;
  cstu_pkg::tok_t        cur_tok;
  logic                  fire;
  logic                  out_xfer;

  // scan the held byte: emitted tokens and the next state in one pass
  always_comb begin
    step_ctx = cstu_pkg::f_step(st_r, in_byte_r, in_end_r, pos_r);
    st_nxt   = step_ctx.s;
    pos_nxt  = in_end_r ? '0 : cstu_pkg::sat_inc(pos_r);
  end

  // the bank is free when empty or when its final token leaves now
  assign out_xfer  = out_tvalid && out_tready;
  assign fire      = in_v_r && ((rem_r == 3'd0) || ((rem_r == 3'd1) && out_tready));
  assign in_tready = !in_v_r || fire;

  assign cur_tok    = bank_r[head_r];
  assign out_tvalid = (rem_r != 3'd0);
  assign out_tlast  = (rem_r == 3'd1);
  assign out_tdata  = {{cstu_pkg::TPAD_W{1'b0}}, cur_tok.cls, cur_tok.len, cur_tok.start};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
      rem_r  <= 3'd0;
      head_r <= 2'd0;
    end else begin
      if (in_tvalid && in_tready) begin
        in_v_r <= 1'b1;
      end else if (fire) begin
        in_v_r <= 1'b0;
      end
      if (fire) begin
        rem_r  <= step_ctx.n;
        head_r <= 2'd0;
      end else if (out_xfer) begin
        rem_r  <= rem_r - 3'd1;
        head_r <= head_r + 2'd1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_end_r  <= in_tlast;
    end
    if (fire) begin
      bank_r <= step_ctx.tok;
    end
  end

  // scan state: control fields reset, lookahead and word bytes do not
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode  <= cstu_pkg::MODE_IDLE;
      st_r.start <= '0;
      st_r.len   <= '0;
      st_r.lac   <= 2'd0;
      st_r.wlen  <= '0;
      st_r.pv    <= 1'b0;
      st_r.inc   <= 1'b0;
      st_r.esc   <= 1'b0;
      pos_r      <= '0;
    end else if (fire) begin
      st_r  <= st_nxt;
      pos_r <= pos_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/cstu_checker.sv
`default_nettype none
`include "c_source_tokenizer_unit_macros.svh"
module cstu_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [55:0] out_tdata,
  input wire logic        out_tlast
);

  `CSTU_ASSERT_IMP(a_idle_ready, !out_tvalid, in_tready, "input stalled with bank empty")
  `CSTU_ASSERT_IMP(a_len_nonzero, out_tvalid, out_tdata[47:24] != 24'd0, "zero length token")
  `CSTU_ASSERT_IMP(a_class_range, out_tvalid, out_tdata[53:48] <= 6'd35, "class out of range")
  `CSTU_ASSERT_NXT(a_more_follow, out_tvalid && out_tready && !out_tlast, out_tvalid, "token run cut short")
  `CSTU_ASSERT_NXT(a_stall_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled token changed")

endmodule

bind c_source_tokenizer_unit cstu_checker u_cstu_checker (.*);
`default_nettype wire
